// File: hw/rtl/bmbe_pkg.sv
// Shared constants and types for the binary mask boundary extraction core.
`timescale 1ns / 1ps
`default_nettype none
package bmbe_pkg;

	// Configuration register widths as seen on the configuration port
	localparam int IMAGE_WIDTH_W   = 13;
	localparam int COLUMN_LENGTH_W = 11;
	localparam int CFG_DATA_W      = 13;
	localparam int CFG_IDX_W       = 1;

	// Stream word widths (fields padded to whole bytes)
	localparam int S_TDATA_W = 8;
	localparam int M_TDATA_W = 8;

	// Column store word: one bit per remembered column, per row
	localparam int WORD_W    = 2;
	localparam int PREV_COL  = 0;	// column just before the current one
	localparam int PREV2_COL = 1;	// two columns back

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_IMAGE_WIDTH   = 1'b0,
		REG_COLUMN_LENGTH = 1'b1
	} cfg_reg_t;

	typedef enum logic {
		FUNC_PIXEL = 1'b0,
		FUNC_FLUSH = 1'b1
	} func_t;

endpackage
`default_nettype wire

// File: hw/rtl/bmbe_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bmbe_ram #(
	parameter int WIDTH = 2,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Read-first: a read and a write to the same entry return the old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
`default_nettype wire

// File: hw/rtl/binary_mask_boundary_extract_core.sv
// Top level: 4-connected boundary extraction of a column-major binary mask stream.
//
//  channel  dir  handshake            payload
//  s_*      in   s_tvalid/s_tready    s_tdata[0]=mask_bit, s_tuser=func
//  m_*      out  m_tvalid/m_tready    m_tdata[0]=boundary_bit, m_tlast=last
//  cfg_*    in   cfg_valid/cfg_ready  cfg_index (0 width, 1 column length), cfg_data
//
// One word per cycle sustained while m_* is not stalled; a result reaches m_*
// after the pixel to its right (or the flush word) is taken, through the registered
// read of the column store, held with stage 1, and then the output register.
// The column store holds two columns per row, one read and one write a cycle.
// Reset clears positions and valid flags; the store itself needs no clearing.
// A stalled output holds the pipeline stage; s_tready stays high while it is free.
`timescale 1ns / 1ps
`default_nettype none
module binary_mask_boundary_extract_core #(
	parameter int MAX_COLUMN_LENGTH = 1024,
	parameter int MAX_WIDTH         = 4096
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	// input words
	input  wire logic                                s_tvalid,
	output logic                                     s_tready,
	input  wire logic [bmbe_pkg::S_TDATA_W-1:0]      s_tdata,   // [0] mask_bit
	input  wire logic                                s_tuser,   // [0] func
	// result words
	output logic                                     m_tvalid,
	input  wire logic                                m_tready,
	output logic      [bmbe_pkg::M_TDATA_W-1:0]      m_tdata,   // [0] boundary_bit
	output logic                                     m_tlast,
	// configuration writes
	input  wire logic                                cfg_valid,
	output logic                                     cfg_ready,
	input  wire logic [bmbe_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  wire logic [bmbe_pkg::CFG_DATA_W-1:0]     cfg_data
);
	import bmbe_pkg::*;

	localparam int XW = $clog2(MAX_WIDTH + 1);
	localparam int HW = $clog2(MAX_COLUMN_LENGTH + 1);
	localparam int YW = (MAX_COLUMN_LENGTH > 1) ? $clog2(MAX_COLUMN_LENGTH) : 1;

	// configuration and position state
	logic [XW-1:0] w_q, x_q;
	logic [HW-1:0] h_q;
	logic [YW-1:0] y_q, fy_q;

	// stage 1
	logic          vld_s1, flush_s1, emit_s1, bit_s1, col1_s1, rtop_s1, rbot_s1;
	logic [YW-1:0] row_s1;

	// window history
	logic [WORD_W-1:0] nxt_q;
	logic              up_q, d1_q, d2_q;

	// output register
	logic out_vld_q, bnd_q, last_q;

	// column store port signals
	logic              ram_we, ram_re;
	logic [YW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	// front-end decode
	logic          acc, enter, is_flush, all_in, y_last, fy_last;
	logic [HW-1:0] y_inc, fy_inc;
	logic [YW-1:0] y_next;

	// stage-1 compute
	logic s1_go, res_vld, a_cur, c_flush, border, nb_clear, bnd_d;

	// clamped configuration values
	logic [31:0]   w_raw, h_raw;
	logic [XW-1:0] w_new;
	logic [HW-1:0] h_new;
	logic          cfg_acc;

	// ---------------------------------------------------------------------
	// Configuration clamp
	always_comb begin
		w_raw = 32'(cfg_data[IMAGE_WIDTH_W-1:0]);
		h_raw = 32'(cfg_data[COLUMN_LENGTH_W-1:0]);
		priority if (w_raw == 32'd0) begin
			w_new = XW'(1);
		end else if (w_raw > 32'(MAX_WIDTH)) begin
			w_new = XW'(MAX_WIDTH);
		end else begin
			w_new = XW'(w_raw);
		end
		priority if (h_raw == 32'd0) begin
			h_new = HW'(1);
		end else if (h_raw > 32'(MAX_COLUMN_LENGTH)) begin
			h_new = HW'(MAX_COLUMN_LENGTH);
		end else begin
			h_new = HW'(h_raw);
		end
	end

	assign cfg_ready = 1'b1;
	assign cfg_acc   = cfg_valid & cfg_ready;

	// ---------------------------------------------------------------------
	// Input decode: which words enter the pipeline
	assign s1_go    = vld_s1 & (~out_vld_q | m_tready);
	assign s_tready = ~vld_s1 | s1_go;
	assign acc      = s_tvalid & s_tready;
	assign is_flush = (func_t'(s_tuser) == FUNC_FLUSH);
	assign all_in   = (x_q == w_q);
	assign enter    = acc & (is_flush ? all_in : ~all_in);

	assign y_inc   = HW'(y_q) + HW'(1);
	assign fy_inc  = HW'(fy_q) + HW'(1);
	assign y_last  = (y_inc == h_q);
	assign fy_last = (fy_inc == h_q);
	assign y_next  = y_last ? '0 : YW'(y_inc);

	// Prefetch the next row for pixels, the drained row for flushes
	assign ram_re    = enter;
	assign ram_raddr = is_flush ? fy_q : y_next;

	// ---------------------------------------------------------------------
	// Stage-1 boundary decision
	always_comb begin
		priority if (h_q == HW'(1)) begin
			a_cur   = d1_q;
			c_flush = d1_q;
		end else if (h_q == HW'(2)) begin
			a_cur   = d2_q;
			c_flush = ram_rdata[PREV_COL];
		end else begin
			a_cur   = nxt_q[PREV_COL];
			c_flush = ram_rdata[PREV_COL];
		end
		border   = col1_s1 | rtop_s1 | rbot_s1;
		// up, down, left, right all set
		nb_clear = ~(up_q & ram_rdata[PREV_COL] & nxt_q[PREV2_COL] & bit_s1);
		bnd_d    = flush_s1 ? c_flush : (a_cur & (border | nb_clear));
		res_vld  = vld_s1 & (flush_s1 | emit_s1);
	end

	// Write back the row: current pixel becomes previous column
	assign ram_we    = s1_go & ~flush_s1;
	assign ram_waddr = row_s1;
	always_comb begin
		ram_wdata            = '0;
		ram_wdata[PREV_COL]  = bit_s1;
		ram_wdata[PREV2_COL] = a_cur;
	end

	bmbe_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAX_COLUMN_LENGTH)
	) u_col_store (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// ---------------------------------------------------------------------
	// Control registers: configuration, positions, valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q       <= XW'(1);
			h_q       <= HW'(MAX_COLUMN_LENGTH);
			x_q       <= '0;
			y_q       <= '0;
			fy_q      <= '0;
			vld_s1    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_acc) begin
				unique case (cfg_reg_t'(cfg_index))
					REG_IMAGE_WIDTH:   w_q <= w_new;
					REG_COLUMN_LENGTH: h_q <= h_new;
					default:           w_q <= w_q;
				endcase
				x_q  <= '0;
				y_q  <= '0;
				fy_q <= '0;
			end else if (enter) begin
				if (is_flush) begin
					if (fy_last) begin
						x_q  <= '0;
						y_q  <= '0;
						fy_q <= '0;
					end else begin
						fy_q <= YW'(fy_inc);
					end
				end else begin
					y_q <= y_next;
					if (y_last) begin
						x_q <= x_q + XW'(1);
					end
				end
			end

			if (s_tready) begin
				vld_s1 <= enter;
			end

			if (s1_go && res_vld) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Stage-1 payload
	always_ff @(posedge clk) begin
		if (enter) begin
			flush_s1 <= is_flush;
			emit_s1  <= (x_q != '0);
			bit_s1   <= s_tdata[0];
			col1_s1  <= (x_q == XW'(1));
			rtop_s1  <= (y_q == '0);
			rbot_s1  <= is_flush ? fy_last : y_last;
			row_s1   <= y_q;
		end
	end

	// Window history advances with each pixel leaving stage 1
	always_ff @(posedge clk) begin
		if (s1_go && !flush_s1) begin
			nxt_q <= ram_rdata;
			up_q  <= a_cur;
			d1_q  <= bit_s1;
			d2_q  <= d1_q;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (s1_go && res_vld) begin
			bnd_q  <= bnd_d;
			last_q <= flush_s1 & rbot_s1;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {(M_TDATA_W - 1)'(0), bnd_q};
	assign m_tlast  = last_q;

	// ---------------------------------------------------------------------
	// Checks
	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(x_q <= w_q) && (HW'(y_q) < h_q) && (HW'(fy_q) < h_q))
		else $error("position outside the image");

	a_no_read_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && !s1_go) |-> !ram_re)
		else $error("column store read while stage 1 is held");

	// the final flush restarts the image as it enters stage 1
	a_flush_after_image: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_s1 && flush_s1) |-> (all_in || ((x_q == '0) && (fy_q == '0))))
		else $error("flush in stage 1 before the image is complete");

	a_drain_row_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!all_in |-> (fy_q == '0))
		else $error("drain row moved before the image is complete");

	a_last_restarts: assert property (@(posedge clk) disable iff (!arst_n)
		(enter && is_flush && fy_last && !cfg_acc) |=> (x_q == '0) && (fy_q == '0))
		else $error("image did not restart after the final result");

endmodule
`default_nettype wire

// File: tb/tb_binary_mask_boundary_extract_core.sv
// Self-checking testbench for the binary mask boundary extraction core.
`timescale 1ns / 1ps
module tb_binary_mask_boundary_extract_core;
	import bmbe_pkg::*;

	localparam int MAX_COLUMN_LENGTH = 1024;
	localparam int MAX_WIDTH         = 4096;
	localparam int RING_DEPTH        = 2 * MAX_COLUMN_LENGTH;
	localparam int SETTLE_CYCLES     = 8;	// pipeline drain before a register write
	localparam int WATCHDOG_LIMIT    = 4000;
	localparam int REPORT_LIMIT      = 10;

	typedef struct packed {
		logic boundary;
		logic last;
	} result_t;

	logic                   clk       = 1'b0;
	logic                   arst_n    = 1'b0;
	logic                   s_tvalid  = 1'b0;
	logic                   s_tready;
	logic [S_TDATA_W-1:0]   s_tdata   = '0;
	logic                   s_tuser   = 1'b0;
	logic                   m_tvalid;
	logic                   m_tready  = 1'b0;
	logic [M_TDATA_W-1:0]   m_tdata;
	logic                   m_tlast;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DATA_W-1:0]  cfg_data  = '0;

	int unsigned src_idle_pct   = 0;
	int unsigned sink_stall_pct = 0;
	int unsigned words_sent     = 0;
	int unsigned error_count    = 0;
	int unsigned quiet_cycles   = 0;

	// Predictor state: two-column ring of pixels, positions and registers
	bit                       mask_ring [0:RING_DEPTH-1];
	int unsigned              row_pos;
	int unsigned              col_pos;
	int unsigned              emit_cnt;
	logic [IMAGE_WIDTH_W-1:0]   width_reg;
	logic [COLUMN_LENGTH_W-1:0] length_reg;
	result_t                  boundary_q [$];

	binary_mask_boundary_extract_core #(
		.MAX_COLUMN_LENGTH(MAX_COLUMN_LENGTH),
		.MAX_WIDTH        (MAX_WIDTH)
	) i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),	// [0] mask_bit
		.s_tuser  (s_tuser),	// [0] func
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),	// [0] boundary_bit
		.m_tlast  (m_tlast),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	// 2 ns clock
	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------
	// Boundary predictor
	// ---------------------------------------------------------------
	function automatic int unsigned eff_width();
		if (width_reg == 0) return 1;
		if (width_reg > MAX_WIDTH) return MAX_WIDTH;
		return 32'(width_reg);
	endfunction

	function automatic int unsigned eff_length();
		if (length_reg == 0) return 1;
		if (length_reg > MAX_COLUMN_LENGTH) return MAX_COLUMN_LENGTH;
		return 32'(length_reg);
	endfunction

	function automatic void restart_image();
		row_pos  = 0;
		col_pos  = 0;
		emit_cnt = 0;
	endfunction

	// pixel at linear index idx; the word being taken in is not yet in the ring
	function automatic bit ring_bit(int unsigned idx, int unsigned h, bit has_cur,
			int unsigned cur_idx, bit cur_val);
		if (has_cur && idx == cur_idx) return cur_val;
		return mask_ring[idx % (2 * h)];
	endfunction

	function automatic void push_boundary(int unsigned w, int unsigned h, bit has_cur,
			int unsigned cur_idx, bit cur_val);
		int unsigned p;
		int unsigned px;
		int unsigned py;
		result_t     r;
		p  = emit_cnt;
		px = p / h;
		py = p % h;
		r.boundary = 1'b0;
		if (ring_bit(p, h, has_cur, cur_idx, cur_val)) begin
			if (px == 0 || px == w - 1 || py == 0 || py == h - 1) begin
				r.boundary = 1'b1;
			end else if (!ring_bit(p - 1, h, has_cur, cur_idx, cur_val) ||
					!ring_bit(p + 1, h, has_cur, cur_idx, cur_val) ||
					!ring_bit(p - h, h, has_cur, cur_idx, cur_val) ||
					!ring_bit(p + h, h, has_cur, cur_idx, cur_val)) begin
				r.boundary = 1'b1;
			end
		end
		r.last = (p + 1 == w * h);
		boundary_q.push_back(r);
		emit_cnt = p + 1;
		if (emit_cnt >= w * h) restart_image();
	endfunction

	function automatic void predict_word(func_t f, bit m);
		int unsigned w;
		int unsigned h;
		int unsigned k;
		w = eff_width();
		h = eff_length();
		if (col_pos > w) col_pos = w;
		if (row_pos >= h) row_pos = 0;
		if (f == FUNC_FLUSH) begin
			// flush drains only once the whole image is in
			if (col_pos >= w && emit_cnt < w * h) push_boundary(w, h, 1'b0, 0, 1'b0);
		end else if (col_pos < w) begin
			k = col_pos * h + row_pos;
			if (k >= h && emit_cnt < w * h) push_boundary(w, h, 1'b1, k, m);
			mask_ring[k % (2 * h)] = m;
			row_pos++;
			if (row_pos >= h) begin
				row_pos = 0;
				col_pos++;
			end
		end
	endfunction

	function automatic void predict_cfg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		case (idx)
			REG_IMAGE_WIDTH:   width_reg  = val[IMAGE_WIDTH_W-1:0];
			REG_COLUMN_LENGTH: length_reg = val[COLUMN_LENGTH_W-1:0];
			default: ;
		endcase
		restart_image();
	endfunction

	initial begin
		foreach (mask_ring[i]) mask_ring[i] = 1'b0;
		width_reg  = IMAGE_WIDTH_W'(1);
		length_reg = COLUMN_LENGTH_W'(MAX_COLUMN_LENGTH);
		restart_image();
	end

	// ---------------------------------------------------------------
	// Drivers
	// ---------------------------------------------------------------
	task automatic send_word(func_t f, bit m);
		while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= f;
		s_tdata  <= {{(S_TDATA_W-1){1'b0}}, m};
		do @(posedge clk); while (!s_tready);
		predict_word(f, m);
		words_sent++;
	endtask

	// registers change only with the block idle
	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] val);
		s_tvalid <= 1'b0;
		while (boundary_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		predict_cfg(idx, val);
	endtask

	// one image in column order, then the flushes for its last column;
	// stop_at below the pixel count cuts the image short with no flush
	task automatic send_image(int unsigned cols, int unsigned rows, int unsigned set_pct,
			bit noisy, int unsigned stop_at);
		int unsigned n_pix;
		int unsigned stray_at;
		n_pix    = cols * rows;
		stray_at = noisy ? $urandom_range(n_pix - 1) : n_pix;
		for (int unsigned i = 0; i < n_pix && i < stop_at; i++) begin
			if (i == stray_at) send_word(FUNC_FLUSH, 1'($urandom_range(1)));	// early flush
			send_word(FUNC_PIXEL, $urandom_range(99) < set_pct);
		end
		if (stop_at >= n_pix) begin
			if (noisy) send_word(FUNC_PIXEL, 1'($urandom_range(1)));	// past the image
			for (int unsigned i = 0; i < rows; i++)
				send_word(FUNC_FLUSH, 1'($urandom_range(1)));
			if (noisy) send_word(FUNC_FLUSH, 1'($urandom_range(1)));	// nothing left to drain
		end
	endtask

	// receiver backpressure
	always @(posedge clk) begin
		m_tready <= ($urandom_range(99) >= sink_stall_pct);
	end

	// ---------------------------------------------------------------
	// Result checker
	// ---------------------------------------------------------------
	task automatic note_mismatch(string what, logic [1:0] want, logic [1:0] got);
		error_count++;
		if (error_count <= REPORT_LIMIT)
			$display("ERROR %s: expected boundary/last %b, got %b", what, want, got);
	endtask

	always @(posedge clk) begin
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (boundary_q.size() == 0) begin
				note_mismatch("unexpected word", 2'bxx, {m_tdata[0], m_tlast});
			end else begin
				want = boundary_q.pop_front();
				if (m_tdata[0] !== want.boundary || m_tlast !== want.last)
					note_mismatch("field mismatch", want, {m_tdata[0], m_tlast});
			end
		end
	end

	// watchdog on cycles with no handshake anywhere
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("binary_mask_boundary_extract_core: mismatch");
			$finish;
		end
	end

	// ---------------------------------------------------------------
	// Tests
	// ---------------------------------------------------------------
	// solid 3x3: interior pixel clear, plus flushes and pixels out of place
	task automatic test_stray_words();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_COLUMN_LENGTH, CFG_DATA_W'(3));
		send_image(3, 3, 100, 1'b1, 9);
	endtask

	// single column (width clamped up from 0) and single row (length from 0)
	task automatic test_narrow_images();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(0));
		write_reg(REG_COLUMN_LENGTH, CFG_DATA_W'(2));
		send_image(1, 2, 70, 1'b0, 2);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(3));
		write_reg(REG_COLUMN_LENGTH, CFG_DATA_W'(0));
		send_image(3, 1, 70, 1'b0, 3);
	endtask

	// a register write in the middle of an image starts a new one
	task automatic test_restart_mid_image();
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
		write_reg(REG_COLUMN_LENGTH, CFG_DATA_W'(4));
		send_image(4, 4, 80, 1'b0, 7);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(4));
		send_image(4, 4, 80, 1'b0, 16);
	endtask

	// largest sizes, both clamped from above; both images are cut short,
	// the tall one just past its first column
	task automatic test_extreme_sizes();
		write_reg(REG_IMAGE_WIDTH, {CFG_DATA_W{1'b1}});
		write_reg(REG_COLUMN_LENGTH, CFG_DATA_W'(1));
		send_image(MAX_WIDTH, 1, 60, 1'b0, 32);
		write_reg(REG_IMAGE_WIDTH, CFG_DATA_W'(2));
		write_reg(REG_COLUMN_LENGTH, CFG_DATA_W'({COLUMN_LENGTH_W{1'b1}}));
		send_image(2, MAX_COLUMN_LENGTH, 90, 1'b0, MAX_COLUMN_LENGTH + 16);
	endtask

	task automatic test_random_images(int unsigned src_pct, int unsigned sink_pct,
			int unsigned goal);
		int unsigned    start;
		int unsigned    cols;
		int unsigned    rows;
		int unsigned    n_pix;
		int unsigned    set_pct;
		logic [CFG_DATA_W-1:0] wdata;
		logic [CFG_DATA_W-1:0] ldata;
		src_idle_pct   = src_pct;
		sink_stall_pct = sink_pct;
		start          = words_sent;
		while (words_sent - start < goal) begin
			cols  = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			rows  = ($urandom_range(7) == 0) ? $urandom_range(9, 24) : $urandom_range(1, 8);
			wdata = (cols == 1 && $urandom_range(1)) ? '0 : CFG_DATA_W'(cols);
			// upper data bits lie outside the length register
			ldata = {2'($urandom_range(3)),
				(rows == 1 && $urandom_range(1)) ? 11'd0 : 11'(rows)};
			write_reg(REG_IMAGE_WIDTH, wdata);
			write_reg(REG_COLUMN_LENGTH, ldata);
			case ($urandom_range(3))
				0:       set_pct = 50;
				1:       set_pct = 80;
				2:       set_pct = 95;
				default: set_pct = 100;
			endcase
			n_pix = cols * rows;
			send_image(cols, rows, set_pct, $urandom_range(9) == 0,
				($urandom_range(19) == 0) ? $urandom_range(n_pix - 1) : n_pix);
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_stray_words();
		test_narrow_images();
		test_restart_mid_image();
		test_extreme_sizes();
		test_random_images(0, 0, 45);
		test_random_images(81, 0, 45);
		test_random_images(0, 81, 45);
		test_random_images(14, 14, 45);
		s_tvalid <= 1'b0;
		while (boundary_q.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (error_count == 0) begin
			$display("binary_mask_boundary_extract_core: match");
		end else begin
			$display("binary_mask_boundary_extract_core: mismatch");
		end
		$finish;
	end

endmodule
